// ===== src/pptu_pkg.sv =====
package pptu_pkg;

   // field widths
   localparam int DT_W   = 20;
   localparam int DT2_W  = 24;
   localparam int WORD_W = 32;
   localparam int SPAN_W = 31;
   localparam int PV_W   = 53;
   localparam int PA_W   = 57;
   localparam int SUM_W  = 42;
   localparam int CSR_W  = 3;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_SPAWN_X     = 3'd0;
   localparam logic [CSR_W-1:0] CSR_SPAWN_Y     = 3'd1;
   localparam logic [CSR_W-1:0] CSR_SPAWN_VX    = 3'd2;
   localparam logic [CSR_W-1:0] CSR_SPAWN_VY    = 3'd3;
   localparam logic [CSR_W-1:0] CSR_SPAWN_AX    = 3'd4;
   localparam logic [CSR_W-1:0] CSR_SPAWN_AY    = 3'd5;
   localparam logic [CSR_W-1:0] CSR_LIFE_SPAN   = 3'd6;
   localparam logic [CSR_W-1:0] CSR_EMIT_PERIOD = 3'd7;

   // reset values
   localparam logic [SPAN_W-1:0] LIFE_SPAN_RST   = 31'd65536;
   localparam logic [SPAN_W-1:0] EMIT_PERIOD_RST = 31'd6554;

   // one pool entry
   typedef struct packed {
      logic signed [WORD_W-1:0] pos_x;
      logic signed [WORD_W-1:0] pos_y;
      logic signed [WORD_W-1:0] vel_x;
      logic signed [WORD_W-1:0] vel_y;
      logic signed [WORD_W-1:0] acc_x;
      logic signed [WORD_W-1:0] acc_y;
      logic signed [WORD_W-1:0] life;
   } particle_type;

   // sequencer states
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_START = 8'b0000_0010,
      ST_MUL   = 8'b0000_0100,
      ST_SUM   = 8'b0000_1000,
      ST_WB    = 8'b0001_0000,
      ST_TIMER = 8'b0010_0000,
      ST_ORD   = 8'b0100_0000,
      ST_OLOAD = 8'b1000_0000
   } state_type;

   // clamp a wide signed sum to 32 bits
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      if (v > 42'sd2147483647) begin
         r = 32'sh7fff_ffff;
      end else if (v < -42'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = $signed(v[WORD_W-1:0]);
      end
      return r;
   endfunction

endpackage

// ===== src/particle_pool_tick_update.sv =====
// Particle pool tick update.
// Input channel req_*: one beat carries tick_dt (unsigned Q4.16 s) and
// advances the whole pool by that time. Result channel rsp_*: one beat per
// active slot in slot order, rsp_last marking the final beat of the tick; an
// empty pool gives a single beat with rsp_present low. Configuration port
// csr_*: spawn position, velocity, acceleration, life span and emission
// period, written by index. The user must write them only while the block is
// idle; the block itself does not enforce this.
// Sequence: a tick runs a setup step, one visit per slot (read, multiply, sum
// and write back through the pool memory; a removed particle causes one extra
// visit of its slot), the emission step and then the result beats; the single
// read port of the pool memory serialises the slot visits.
// The next tick is taken once the last result beat sits in the output
// register; a stalled receiver holds that register and delays the following
// tick's first result only.
// Reset clears the pool count, loads the emission timer and the registers
// with their defaults; pool memory contents are not cleared.
module particle_pool_tick_update #(
   parameter int MAX_PARTICLES = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // tick input
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pptu_pkg::DT_W-1:0]            req_tick_dt,
   // results
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_present,
   output logic [5:0]                           rsp_slot,
   output logic signed [pptu_pkg::WORD_W-1:0]   rsp_pos_x,
   output logic signed [pptu_pkg::WORD_W-1:0]   rsp_pos_y,
   output logic signed [pptu_pkg::WORD_W-1:0]   rsp_life_left,
   output logic [6:0]                           rsp_active_count,
   output logic                                 rsp_last,
   // configuration writes
   input  logic                                 csr_write_en,
   input  logic [pptu_pkg::CSR_W-1:0]           csr_index,
   input  logic [pptu_pkg::WORD_W-1:0]          csr_data
);

   localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARTICLES);

   // pool memory
   pptu_pkg::particle_type pool_mem [MAX_PARTICLES];
   pptu_pkg::particle_type rd_data_ff;
   pptu_pkg::particle_type wr_data;
   logic                   mem_we;
   logic                   mem_re;
   logic [IDX_W-1:0]       wr_addr;
   logic [IDX_W-1:0]       rd_addr;

   // control state
   pptu_pkg::state_type              state_ff, state_in;
   logic [CNT_W-1:0]                 total_ff, total_in;
   logic [CNT_W-1:0]                 slot_ff, slot_in;
   logic [CNT_W-1:0]                 oidx_ff, oidx_in;
   logic signed [pptu_pkg::WORD_W-1:0] timer_ff, timer_in;

   // tick operands and datapath registers
   logic [pptu_pkg::DT_W-1:0]          dt_ff, dt_in;
   logic [pptu_pkg::DT2_W-1:0]         dt2_ff, dt2_in;
   logic signed [pptu_pkg::PV_W-1:0]   pvx_ff, pvx_in, pvy_ff, pvy_in;
   logic signed [pptu_pkg::PA_W-1:0]   pax_ff, pax_in, pay_ff, pay_in;
   logic signed [pptu_pkg::WORD_W-1:0] new_px_ff, new_px_in;
   logic signed [pptu_pkg::WORD_W-1:0] new_py_ff, new_py_in;
   logic signed [pptu_pkg::WORD_W-1:0] new_life_ff, new_life_in;

   // configuration registers
   logic signed [pptu_pkg::WORD_W-1:0] spawn_x_ff, spawn_x_in, spawn_y_ff, spawn_y_in;
   logic signed [pptu_pkg::WORD_W-1:0] spawn_vx_ff, spawn_vx_in, spawn_vy_ff, spawn_vy_in;
   logic signed [pptu_pkg::WORD_W-1:0] spawn_ax_ff, spawn_ax_in, spawn_ay_ff, spawn_ay_in;
   logic [pptu_pkg::SPAN_W-1:0]        life_span_ff, life_span_in;
   logic [pptu_pkg::SPAN_W-1:0]        emit_period_ff, emit_period_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_present_ff, rsp_present_in;
   logic [5:0]                         rsp_slot_ff, rsp_slot_in;
   logic signed [pptu_pkg::WORD_W-1:0] rsp_pos_x_ff, rsp_pos_x_in;
   logic signed [pptu_pkg::WORD_W-1:0] rsp_pos_y_ff, rsp_pos_y_in;
   logic signed [pptu_pkg::WORD_W-1:0] rsp_life_ff, rsp_life_in;
   logic [6:0]                         rsp_count_ff, rsp_count_in;
   logic                               rsp_last_ff, rsp_last_in;

   // arithmetic helpers
   logic [2*pptu_pkg::DT_W-1:0]        dt_sq;
   logic signed [pptu_pkg::DT_W:0]     dt_s;
   logic signed [pptu_pkg::SUM_W-1:0]  sum_x, sum_y, sum_life, sum_timer;
   logic signed [pptu_pkg::WORD_W-1:0] timer_next;
   logic [CNT_W-1:0]                   slot_plus, total_minus, oidx_plus;
   logic                               life_alive, rsp_free;

   assign dt_s        = $signed({1'b0, dt_ff});
   assign dt_sq       = (2*pptu_pkg::DT_W)'(dt_ff) * (2*pptu_pkg::DT_W)'(dt_ff);
   assign slot_plus   = slot_ff + 1'b1;
   assign total_minus = total_ff - 1'b1;
   assign oidx_plus   = oidx_ff + 1'b1;
   assign life_alive  = !new_life_ff[pptu_pkg::WORD_W-1] && (new_life_ff != '0);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   // position update: p + floor(dt*v/2^16) + floor(dt2*a/2^17)
   assign sum_x = pptu_pkg::SUM_W'(rd_data_ff.pos_x)
                + pptu_pkg::SUM_W'(pvx_ff >>> 16)
                + pptu_pkg::SUM_W'(pax_ff >>> 17);
   assign sum_y = pptu_pkg::SUM_W'(rd_data_ff.pos_y)
                + pptu_pkg::SUM_W'(pvy_ff >>> 16)
                + pptu_pkg::SUM_W'(pay_ff >>> 17);
   assign sum_life  = pptu_pkg::SUM_W'(rd_data_ff.life) - pptu_pkg::SUM_W'(dt_s);
   assign sum_timer = pptu_pkg::SUM_W'(timer_ff) - pptu_pkg::SUM_W'(dt_s);
   assign timer_next = pptu_pkg::sat_word(sum_timer);

   // pool memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pool_mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= pool_mem[rd_addr];
      end
   end

   // next-state logic
   always_comb begin
      state_in       = state_ff;
      total_in       = total_ff;
      slot_in        = slot_ff;
      oidx_in        = oidx_ff;
      timer_in       = timer_ff;
      dt_in          = dt_ff;
      dt2_in         = dt2_ff;
      pvx_in         = pvx_ff;
      pvy_in         = pvy_ff;
      pax_in         = pax_ff;
      pay_in         = pay_ff;
      new_px_in      = new_px_ff;
      new_py_in      = new_py_ff;
      new_life_in    = new_life_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_present_in = rsp_present_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_pos_x_in   = rsp_pos_x_ff;
      rsp_pos_y_in   = rsp_pos_y_ff;
      rsp_life_in    = rsp_life_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      wr_addr        = slot_ff[IDX_W-1:0];
      rd_addr        = slot_ff[IDX_W-1:0];
      wr_data        = rd_data_ff;

      // configuration beat
      spawn_x_in     = spawn_x_ff;
      spawn_y_in     = spawn_y_ff;
      spawn_vx_in    = spawn_vx_ff;
      spawn_vy_in    = spawn_vy_ff;
      spawn_ax_in    = spawn_ax_ff;
      spawn_ay_in    = spawn_ay_ff;
      life_span_in   = life_span_ff;
      emit_period_in = emit_period_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            pptu_pkg::CSR_SPAWN_X:     spawn_x_in     = $signed(csr_data);
            pptu_pkg::CSR_SPAWN_Y:     spawn_y_in     = $signed(csr_data);
            pptu_pkg::CSR_SPAWN_VX:    spawn_vx_in    = $signed(csr_data);
            pptu_pkg::CSR_SPAWN_VY:    spawn_vy_in    = $signed(csr_data);
            pptu_pkg::CSR_SPAWN_AX:    spawn_ax_in    = $signed(csr_data);
            pptu_pkg::CSR_SPAWN_AY:    spawn_ay_in    = $signed(csr_data);
            pptu_pkg::CSR_LIFE_SPAN:   life_span_in   = csr_data[pptu_pkg::SPAN_W-1:0];
            pptu_pkg::CSR_EMIT_PERIOD: emit_period_in = csr_data[pptu_pkg::SPAN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         // wait for a tick beat
         pptu_pkg::ST_IDLE: begin
            if (req_valid) begin
               dt_in    = req_tick_dt;
               state_in = pptu_pkg::ST_START;
            end
         end
         // square dt and fetch slot 0
         pptu_pkg::ST_START: begin
            dt2_in  = dt_sq[16 +: pptu_pkg::DT2_W];
            slot_in = '0;
            if (total_ff != '0) begin
               mem_re   = 1'b1;
               rd_addr  = '0;
               state_in = pptu_pkg::ST_MUL;
            end else begin
               state_in = pptu_pkg::ST_TIMER;
            end
         end
         // velocity and acceleration products
         pptu_pkg::ST_MUL: begin
            pvx_in   = dt_s * rd_data_ff.vel_x;
            pvy_in   = dt_s * rd_data_ff.vel_y;
            pax_in   = $signed({1'b0, dt2_ff}) * rd_data_ff.acc_x;
            pay_in   = $signed({1'b0, dt2_ff}) * rd_data_ff.acc_y;
            state_in = pptu_pkg::ST_SUM;
         end
         // saturating sums
         pptu_pkg::ST_SUM: begin
            new_px_in   = pptu_pkg::sat_word(sum_x);
            new_py_in   = pptu_pkg::sat_word(sum_y);
            new_life_in = pptu_pkg::sat_word(sum_life);
            state_in    = pptu_pkg::ST_WB;
         end
         // write back a live particle, or pull the last one into this slot
         pptu_pkg::ST_WB: begin
            if (life_alive) begin
               mem_we        = 1'b1;
               wr_data.pos_x = new_px_ff;
               wr_data.pos_y = new_py_ff;
               wr_data.life  = new_life_ff;
               slot_in       = slot_plus;
               if (slot_plus < total_ff) begin
                  mem_re   = 1'b1;
                  rd_addr  = slot_plus[IDX_W-1:0];
                  state_in = pptu_pkg::ST_MUL;
               end else begin
                  state_in = pptu_pkg::ST_TIMER;
               end
            end else begin
               total_in = total_minus;
               if (slot_ff < total_minus) begin
                  mem_re   = 1'b1;
                  rd_addr  = total_minus[IDX_W-1:0];
                  state_in = pptu_pkg::ST_MUL;
               end else begin
                  state_in = pptu_pkg::ST_TIMER;
               end
            end
         end
         // emission timer and spawn
         pptu_pkg::ST_TIMER: begin
            oidx_in  = '0;
            state_in = pptu_pkg::ST_ORD;
            if (timer_next[pptu_pkg::WORD_W-1] || (timer_next == '0)) begin
               timer_in = $signed({1'b0, emit_period_ff});
               if (total_ff < MAX_CNT) begin
                  mem_we        = 1'b1;
                  wr_addr       = total_ff[IDX_W-1:0];
                  wr_data.pos_x = spawn_x_ff;
                  wr_data.pos_y = spawn_y_ff;
                  wr_data.vel_x = spawn_vx_ff;
                  wr_data.vel_y = spawn_vy_ff;
                  wr_data.acc_x = spawn_ax_ff;
                  wr_data.acc_y = spawn_ay_ff;
                  wr_data.life  = $signed({1'b0, life_span_ff});
                  total_in      = total_ff + 1'b1;
               end
            end else begin
               timer_in = timer_next;
            end
         end
         // fetch the first slot for the report
         pptu_pkg::ST_ORD: begin
            mem_re   = 1'b1;
            rd_addr  = '0;
            state_in = pptu_pkg::ST_OLOAD;
         end
         // one result beat per slot, next read issued as each loads
         pptu_pkg::ST_OLOAD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = 7'(total_ff);
               if (total_ff == '0) begin
                  rsp_present_in = 1'b0;
                  rsp_slot_in    = '0;
                  rsp_pos_x_in   = '0;
                  rsp_pos_y_in   = '0;
                  rsp_life_in    = '0;
                  rsp_last_in    = 1'b1;
                  state_in       = pptu_pkg::ST_IDLE;
               end else begin
                  rsp_present_in = 1'b1;
                  rsp_slot_in    = 6'(oidx_ff);
                  rsp_pos_x_in   = rd_data_ff.pos_x;
                  rsp_pos_y_in   = rd_data_ff.pos_y;
                  rsp_life_in    = rd_data_ff.life;
                  rsp_last_in    = (oidx_plus == total_ff);
                  oidx_in        = oidx_plus;
                  if (oidx_plus == total_ff) begin
                     state_in = pptu_pkg::ST_IDLE;
                  end else begin
                     mem_re  = 1'b1;
                     rd_addr = oidx_plus[IDX_W-1:0];
                  end
               end
            end
         end
         default: state_in = pptu_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pptu_pkg::ST_IDLE;
         total_ff       <= '0;
         timer_ff       <= $signed({1'b0, pptu_pkg::EMIT_PERIOD_RST});
         rsp_valid_ff   <= 1'b0;
         spawn_x_ff     <= '0;
         spawn_y_ff     <= '0;
         spawn_vx_ff    <= '0;
         spawn_vy_ff    <= '0;
         spawn_ax_ff    <= '0;
         spawn_ay_ff    <= '0;
         life_span_ff   <= pptu_pkg::LIFE_SPAN_RST;
         emit_period_ff <= pptu_pkg::EMIT_PERIOD_RST;
      end else begin
         state_ff       <= state_in;
         total_ff       <= total_in;
         timer_ff       <= timer_in;
         rsp_valid_ff   <= rsp_valid_in;
         spawn_x_ff     <= spawn_x_in;
         spawn_y_ff     <= spawn_y_in;
         spawn_vx_ff    <= spawn_vx_in;
         spawn_vy_ff    <= spawn_vy_in;
         spawn_ax_ff    <= spawn_ax_in;
         spawn_ay_ff    <= spawn_ay_in;
         life_span_ff   <= life_span_in;
         emit_period_ff <= emit_period_in;
      end
   end

   // datapath and payload registers
   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      oidx_ff        <= oidx_in;
      dt_ff          <= dt_in;
      dt2_ff         <= dt2_in;
      pvx_ff         <= pvx_in;
      pvy_ff         <= pvy_in;
      pax_ff         <= pax_in;
      pay_ff         <= pay_in;
      new_px_ff      <= new_px_in;
      new_py_ff      <= new_py_in;
      new_life_ff    <= new_life_in;
      rsp_present_ff <= rsp_present_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_pos_x_ff   <= rsp_pos_x_in;
      rsp_pos_y_ff   <= rsp_pos_y_in;
      rsp_life_ff    <= rsp_life_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // ports
   assign req_ready        = (state_ff == pptu_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_present      = rsp_present_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_pos_x        = rsp_pos_x_ff;
   assign rsp_pos_y        = rsp_pos_y_ff;
   assign rsp_life_left    = rsp_life_ff;
   assign rsp_active_count = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
